@@ hw/rtl/birth_death_qsd_recursive_solver_macros.svh @@
// Assertion macros for the birth-death QSD solver checker.
// No dependencies; included by the checker file.
`ifndef BIRTH_DEATH_QSD_RECURSIVE_SOLVER_MACROS_SVH
`define BIRTH_DEATH_QSD_RECURSIVE_SOLVER_MACROS_SVH

// same-cycle implication
`define BDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bdq check failed");

// next-cycle implication
`define BDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bdq check failed");

`endif

@@ hw/rtl/bdq_pkg.sv @@
// Shared types, constants and saturation helper for the QSD solver.
// No dependencies.
package bdq_pkg;

    localparam int MAX_POP = 63;
    localparam int DEPTH   = MAX_POP + 1;
    localparam int AW      = $clog2(DEPTH);

    typedef logic signed [42:0] t_weight;
    typedef logic [43:0]        t_coef;
    typedef logic [31:0]        t_rate;
    typedef logic [AW-1:0]      t_addr;

    // 1.0 and the saturation bound in weight format
    localparam t_weight W_ONE    = 43'sh100_0000_0000;
    localparam t_weight W_MAX    = 43'sh200_0000_0000;
    localparam t_coef   COEF_MAX = 44'hFFF_FFFF_FFFF;

    localparam logic [5:0] DIV_STEPS_COEF = 6'd44;
    localparam logic [5:0] DIV_STEPS_NORM = 6'd42;

    // multiply request: (x*y) >> (sh40 ? 40 : 24), saturated
    typedef struct packed {
        logic signed [44:0] x;
        t_weight            y;
        logic               sh40;
    } t_mul_req;

    // divide request: restoring division seeded with a partial remainder
    typedef struct packed {
        logic [47:0] rem;
        logic [43:0] bits;
        logic [5:0]  steps;
        logic [47:0] den;
    } t_div_req;

    function automatic t_weight sat_w(input logic signed [50:0] v);
        logic signed [50:0] hi;
        logic signed [50:0] lo;
        hi = 51'(W_MAX);
        lo = -hi;
        if (v > hi) begin
            sat_w = W_MAX;
        end else if (v < lo) begin
            sat_w = -W_MAX;
        end else begin
            sat_w = v[42:0];
        end
    endfunction

endpackage

@@ hw/rtl/bdq_mul.sv @@
// Shared signed multiplier, summing two 44x21 partial products.
// Depends on bdq_pkg.
module bdq_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bdq_pkg::t_mul_req i_req,
    output logic              o_done,
    output bdq_pkg::t_weight  o_res
);
    import bdq_pkg::*;

    logic [43:0] r_mx;
    logic [41:0] r_my;
    logic        r_neg;
    logic        r_sh40;
    logic [1:0]  r_ph;
    logic        r_busy;
    logic        r_done;
    logic [85:0] r_prod;
    t_weight     r_res;

    logic signed [44:0] ax;
    t_weight            ay;
    logic [20:0]        chunk;
    logic [64:0]        part;
    logic [85:0]        shifted;
    logic [41:0]        mclip;
    t_weight            mv;

    // operand magnitudes at request time
    always_comb begin
        ax = i_req.x[44] ? -i_req.x : i_req.x;
        ay = i_req.y[42] ? -i_req.y : i_req.y;
    end

    assign chunk = (r_ph == 2'd0) ? r_my[20:0] : r_my[41:21];
    assign part  = 65'(r_mx) * 65'(chunk);

    // final shift and clamp
    always_comb begin
        shifted = r_sh40 ? (r_prod >> 40) : (r_prod >> 24);
        mclip   = (shifted > 86'(W_MAX)) ? W_MAX[41:0] : shifted[41:0];
        mv      = {1'b0, mclip};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mx   <= ax[43:0];
                r_my   <= ay[41:0];
                r_neg  <= i_req.x[44] ^ i_req.y[42];
                r_sh40 <= i_req.sh40;
                r_ph   <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                case (r_ph)
                    2'd0: begin
                        r_prod <= 86'(part);
                        r_ph   <= 2'd1;
                    end
                    2'd1: begin
                        r_prod <= r_prod + (86'(part) << 21);
                        r_ph   <= 2'd2;
                    end
                    default: begin
                        r_res  <= r_neg ? -mv : mv;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ hw/rtl/bdq_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bdq_pkg.
module bdq_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bdq_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [43:0]       o_quot
);
    import bdq_pkg::*;

    logic [47:0] r_rem;
    logic [43:0] r_bits;
    logic [47:0] r_den;
    logic [43:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [48:0] trial;
    logic        ge;
    logic [48:0] diff;

    // one compare and subtract step
    always_comb begin
        trial = {r_rem, r_bits[43]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_req.rem;
                r_bits <= i_req.bits;
                r_den  <= i_req.den;
                r_cnt  <= i_req.steps;
                r_q    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? diff[47:0] : trial[47:0];
                r_q    <= {r_q[42:0], ge};
                r_bits <= {r_bits[42:0], 1'b0};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ hw/rtl/birth_death_qsd_recursive_solver.sv @@
// Top level of the birth-death quasi-stationary distribution solver.
// Depends on bdq_pkg, bdq_mul and bdq_div.
//
// Usage: load states 0..N one request per cycle (up rate, down rate, start
// weight); the request with is_last set, or the one at index 63, closes the set
// and starts the solve, during which the input side stalls. The solve first
// builds three ratio coefficients per interior state through the bit-serial
// divider, then iterates; per interior state an iteration runs four products
// through the shared 44x21 multiplier and a normalizing quotient. After
// convergence or the iteration limit the N+1 weights come out in index order,
// one result at a time, each held while the output stalls.
// Config writes are always ready and must only be issued while the block is
// idle. No clearing pass is needed.
module birth_death_qsd_recursive_solver (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // load channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bdq_pkg::t_rate       i_in_up_rate,
    input  bdq_pkg::t_rate       i_in_down_rate,
    input  logic [40:0]          i_in_start_weight,
    input  logic                 i_in_is_last,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [5:0]           o_out_state_index,
    output bdq_pkg::t_weight     o_out_weight,
    output logic                 o_out_converged,
    output logic [15:0]          o_out_iterations_used,
    output logic                 o_out_is_last_result,
    // config channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [40:0]          i_cfg_data
);
    import bdq_pkg::*;

    localparam logic [1:0] CFG_ITER_LIMIT = 2'd0;
    localparam logic [1:0] CFG_TOL        = 2'd1;

    localparam logic [5:0] S_IDLE     = 6'd0;
    localparam logic [5:0] S_C_INIT   = 6'd1;
    localparam logic [5:0] S_C_INITW  = 6'd2;
    localparam logic [5:0] S_C_INITL  = 6'd3;
    localparam logic [5:0] S_C_ADDR   = 6'd4;
    localparam logic [5:0] S_C_WAIT   = 6'd5;
    localparam logic [5:0] S_C_LAT    = 6'd6;
    localparam logic [5:0] S_C_CHK    = 6'd7;
    localparam logic [5:0] S_C_DWAIT  = 6'd8;
    localparam logic [5:0] S_I_INIT   = 6'd9;
    localparam logic [5:0] S_I_Q1W    = 6'd10;
    localparam logic [5:0] S_I_Q1L    = 6'd11;
    localparam logic [5:0] S_I_QLW    = 6'd12;
    localparam logic [5:0] S_I_QLL    = 6'd13;
    localparam logic [5:0] S_P1_ADDR  = 6'd14;
    localparam logic [5:0] S_P1_WAIT  = 6'd15;
    localparam logic [5:0] S_P1_CUM   = 6'd16;
    localparam logic [5:0] S_P1_M1    = 6'd17;
    localparam logic [5:0] S_P1_M2    = 6'd18;
    localparam logic [5:0] S_P1_M3    = 6'd19;
    localparam logic [5:0] S_P1_M4    = 6'd20;
    localparam logic [5:0] S_P2_INIT  = 6'd21;
    localparam logic [5:0] S_P2_W0    = 6'd22;
    localparam logic [5:0] S_P2_Z     = 6'd23;
    localparam logic [5:0] S_P2_ZN    = 6'd24;
    localparam logic [5:0] S_P2_ADDR  = 6'd25;
    localparam logic [5:0] S_P2_WAIT  = 6'd26;
    localparam logic [5:0] S_P2_DIV   = 6'd27;
    localparam logic [5:0] S_P2_DWAIT = 6'd28;
    localparam logic [5:0] S_P2_UPD   = 6'd29;
    localparam logic [5:0] S_I_END    = 6'd30;
    localparam logic [5:0] S_O_ADDR   = 6'd31;
    localparam logic [5:0] S_O_WAIT   = 6'd32;
    localparam logic [5:0] S_O_HOLD   = 6'd33;

    // memories
    t_rate   mem_up [DEPTH];
    t_rate   mem_dn [DEPTH];
    t_weight mem_w  [DEPTH];
    t_weight mem_nx [DEPTH];
    t_coef   mem_ca [DEPTH];
    t_coef   mem_cb [DEPTH];
    t_coef   mem_cg [DEPTH];

    t_rate   r_urd, r_drd;
    t_weight r_wrd, r_nrd;
    t_coef   r_ca, r_cb, r_cg;

    // registers
    logic [5:0]         r_state, n_state;
    t_addr              r_load_cnt, n_load_cnt;
    logic [15:0]        r_iter_limit;
    logic [40:0]        r_tol;
    t_addr              r_ntop, n_ntop;
    t_addr              r_n, n_n;
    logic [1:0]         r_k, n_k;
    t_addr              r_ua, n_ua;
    t_addr              r_da, n_da;
    t_addr              r_wa, n_wa;
    t_rate              r_upl, n_upl;
    t_rate              r_d1, n_d1;
    t_rate              r_upn, n_upn;
    t_rate              r_den, n_den;
    logic signed [48:0] r_cum, n_cum;
    logic signed [48:0] r_norm, n_norm;
    logic [47:0]        r_diff, n_diff;
    t_weight            r_qf, n_qf;
    t_weight            r_ql, n_ql;
    t_weight            r_wprev, n_wprev;
    t_weight            r_gq, n_gq;
    t_weight            r_t, n_t;
    t_weight            r_q, n_q;
    logic [15:0]        r_iter, n_iter;
    logic               r_conv, n_conv;
    t_addr              r_oi, n_oi;

    // datapath control
    logic     in_acc;
    logic     load_last;
    logic     mul_start, mul_done;
    t_mul_req mul_req;
    t_weight  mul_res;
    logic     div_start, div_done;
    t_div_req div_req;
    logic [43:0] div_quot;
    logic     w_we;
    t_addr    w_wa;
    t_weight  w_wd;
    logic     nx_we;
    t_weight  nx_wd;
    logic [2:0] c_we;
    t_coef    c_wd;

    // combinational helpers
    t_rate              c_num;
    t_weight            w_fin;
    t_weight            f_val;
    logic signed [50:0] dq;
    logic signed [50:0] adq;
    logic signed [42:0] a_abs;
    logic [41:0]        am;
    logic signed [48:0] norm_abs;
    logic [47:0]        dm;
    logic               q_neg;
    logic [43:0]        q_clip;
    logic [16:0]        iter_nx;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign load_last   = i_in_is_last || (r_load_cnt == t_addr'(MAX_POP));

    bdq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    bdq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // rate stores
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem_up[r_load_cnt] <= i_in_up_rate;
            mem_dn[r_load_cnt] <= i_in_down_rate;
        end
        r_urd <= mem_up[r_ua];
        r_drd <= mem_dn[r_da];
    end

    // weight stores
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_w[w_wa] <= w_wd;
        end
        if (nx_we) begin
            mem_nx[r_n] <= nx_wd;
        end
        r_wrd <= mem_w[r_wa];
        r_nrd <= mem_nx[r_n];
    end

    // coefficient stores
    always_ff @(posedge i_clk) begin
        if (c_we[0]) begin
            mem_ca[r_n] <= c_wd;
        end
        if (c_we[1]) begin
            mem_cb[r_n] <= c_wd;
        end
        if (c_we[2]) begin
            mem_cg[r_n] <= c_wd;
        end
        r_ca <= mem_ca[r_n];
        r_cb <= mem_cb[r_n];
        r_cg <= mem_cg[r_n];
    end

    // helper values
    always_comb begin
        case (r_k)
            2'd0:    c_num = r_upn;
            2'd1:    c_num = r_d1;
            default: c_num = r_upl;
        endcase
        w_fin    = sat_w(51'(r_t) + 51'(mul_res));
        f_val    = sat_w(51'(W_ONE) - 51'(r_cum));
        a_abs    = r_nrd[42] ? -r_nrd : r_nrd;
        am       = a_abs[41:0];
        norm_abs = r_norm[48] ? -r_norm : r_norm;
        dm       = norm_abs[47:0];
        q_neg    = r_nrd[42] ^ r_norm[48];
        q_clip   = (div_quot > 44'(W_MAX)) ? 44'(W_MAX) : div_quot;
        dq       = 51'(r_q) - 51'(r_wrd);
        adq      = dq[50] ? -dq : dq;
        iter_nx  = {1'b0, r_iter} + 17'd1;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_ntop     = r_ntop;
        n_n        = r_n;
        n_k        = r_k;
        n_ua       = r_ua;
        n_da       = r_da;
        n_wa       = r_wa;
        n_upl      = r_upl;
        n_d1       = r_d1;
        n_upn      = r_upn;
        n_den      = r_den;
        n_cum      = r_cum;
        n_norm     = r_norm;
        n_diff     = r_diff;
        n_qf       = r_qf;
        n_ql       = r_ql;
        n_wprev    = r_wprev;
        n_gq       = r_gq;
        n_t        = r_t;
        n_q        = r_q;
        n_iter     = r_iter;
        n_conv     = r_conv;
        n_oi       = r_oi;
        mul_start  = 1'b0;
        mul_req    = '0;
        div_start  = 1'b0;
        div_req    = '0;
        w_we       = 1'b0;
        w_wa       = r_load_cnt;
        w_wd       = {2'b00, i_in_start_weight};
        nx_we      = 1'b0;
        nx_wd      = w_fin;
        c_we       = 3'b000;
        c_wd       = div_quot;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    w_we = 1'b1;
                    if (load_last) begin
                        n_ntop     = r_load_cnt;
                        n_load_cnt = '0;
                        n_iter     = '0;
                        n_n        = t_addr'(1);
                        n_state    = (r_load_cnt >= t_addr'(2)) ? S_C_INIT : S_I_INIT;
                    end else begin
                        n_load_cnt = r_load_cnt + t_addr'(1);
                    end
                end
            end
            // fixed operands: down[1], up[N-1]
            S_C_INIT: begin
                n_ua    = r_ntop - t_addr'(1);
                n_da    = t_addr'(1);
                n_state = S_C_INITW;
            end
            S_C_INITW: n_state = S_C_INITL;
            S_C_INITL: begin
                n_upl   = r_urd;
                n_d1    = r_drd;
                n_state = S_C_ADDR;
            end
            S_C_ADDR: begin
                n_ua    = r_n - t_addr'(1);
                n_da    = r_n;
                n_state = S_C_WAIT;
            end
            S_C_WAIT: n_state = S_C_LAT;
            S_C_LAT: begin
                n_upn   = r_urd;
                n_den   = r_drd;
                n_k     = 2'd0;
                n_state = S_C_CHK;
            end
            // zero divisor or overflow saturates, otherwise divide
            S_C_CHK: begin
                if (r_den == '0 || {20'b0, c_num[31:20]} >= r_den) begin
                    c_wd         = COEF_MAX;
                    c_we[r_k]    = 1'b1;
                    if (r_k != 2'd2) begin
                        n_k = r_k + 2'd1;
                    end else if ({1'b0, r_n} + 7'd1 < {1'b0, r_ntop}) begin
                        n_n     = r_n + t_addr'(1);
                        n_state = S_C_ADDR;
                    end else begin
                        n_state = S_I_INIT;
                    end
                end else begin
                    div_start     = 1'b1;
                    div_req.rem   = {36'b0, c_num[31:20]};
                    div_req.bits  = {c_num[19:0], 24'b0};
                    div_req.steps = DIV_STEPS_COEF;
                    div_req.den   = {16'b0, r_den};
                    n_state       = S_C_DWAIT;
                end
            end
            S_C_DWAIT: begin
                if (div_done) begin
                    c_we[r_k] = 1'b1;
                    if (r_k != 2'd2) begin
                        n_k     = r_k + 2'd1;
                        n_state = S_C_CHK;
                    end else if ({1'b0, r_n} + 7'd1 < {1'b0, r_ntop}) begin
                        n_n     = r_n + t_addr'(1);
                        n_state = S_C_ADDR;
                    end else begin
                        n_state = S_I_INIT;
                    end
                end
            end
            // iteration start
            S_I_INIT: begin
                n_cum   = '0;
                n_norm  = '0;
                n_diff  = '0;
                n_n     = t_addr'(1);
                n_wa    = t_addr'(1);
                n_state = (r_ntop >= t_addr'(2)) ? S_I_Q1W : S_P2_INIT;
            end
            S_I_Q1W: n_state = S_I_Q1L;
            S_I_Q1L: begin
                n_qf    = r_wrd;
                n_wa    = r_ntop - t_addr'(1);
                n_state = S_I_QLW;
            end
            S_I_QLW: n_state = S_I_QLL;
            S_I_QLL: begin
                n_ql    = r_wrd;
                n_state = S_P1_ADDR;
            end
            // recursive update of interior state n
            S_P1_ADDR: begin
                n_wa    = r_n - t_addr'(1);
                n_state = S_P1_WAIT;
            end
            S_P1_WAIT: n_state = S_P1_CUM;
            S_P1_CUM: begin
                n_cum        = r_cum + 49'(r_wrd);
                n_wprev      = r_wrd;
                mul_start    = 1'b1;
                mul_req.x    = {1'b0, r_cg};
                mul_req.y    = r_ql;
                mul_req.sh40 = 1'b0;
                n_state      = S_P1_M1;
            end
            S_P1_M1: begin
                if (mul_done) begin
                    n_gq         = mul_res;
                    mul_start    = 1'b1;
                    mul_req.x    = {1'b0, r_ca};
                    mul_req.y    = r_wprev;
                    mul_req.sh40 = 1'b0;
                    n_state      = S_P1_M2;
                end
            end
            S_P1_M2: begin
                if (mul_done) begin
                    n_t          = sat_w(51'(mul_res) - 51'(r_gq));
                    mul_start    = 1'b1;
                    mul_req.x    = {1'b0, r_cb};
                    mul_req.y    = r_qf;
                    mul_req.sh40 = 1'b0;
                    n_state      = S_P1_M3;
                end
            end
            S_P1_M3: begin
                if (mul_done) begin
                    mul_start    = 1'b1;
                    mul_req.x    = 45'(sat_w(51'(mul_res) + 51'(r_gq)));
                    mul_req.y    = f_val;
                    mul_req.sh40 = 1'b1;
                    n_state      = S_P1_M4;
                end
            end
            S_P1_M4: begin
                if (mul_done) begin
                    nx_we  = 1'b1;
                    n_norm = r_norm + 49'(w_fin);
                    if ({1'b0, r_n} + 7'd1 < {1'b0, r_ntop}) begin
                        n_n     = r_n + t_addr'(1);
                        n_state = S_P1_ADDR;
                    end else begin
                        n_state = S_P2_INIT;
                    end
                end
            end
            // end states go to zero
            S_P2_INIT: begin
                n_wa    = '0;
                n_state = S_P2_W0;
            end
            S_P2_W0: n_state = S_P2_Z;
            S_P2_Z: begin
                if (r_ntop != '0) begin
                    n_diff = r_diff + (r_wrd[42] ? 48'(-r_wrd) : 48'(r_wrd));
                end
                w_we    = 1'b1;
                w_wa    = '0;
                w_wd    = '0;
                n_state = S_P2_ZN;
            end
            S_P2_ZN: begin
                w_we    = 1'b1;
                w_wa    = r_ntop;
                w_wd    = '0;
                n_n     = t_addr'(1);
                n_state = (r_ntop >= t_addr'(2)) ? S_P2_ADDR : S_I_END;
            end
            // normalize interior state n and accumulate the change
            S_P2_ADDR: begin
                n_wa    = r_n;
                n_state = S_P2_WAIT;
            end
            S_P2_WAIT: n_state = S_P2_DIV;
            S_P2_DIV: begin
                if (dm == '0) begin
                    if (r_nrd == '0) begin
                        n_q = '0;
                    end else begin
                        n_q = r_nrd[42] ? -W_MAX : W_MAX;
                    end
                    n_state = S_P2_UPD;
                end else if ({8'b0, am} >= {dm, 2'b00}) begin
                    n_q     = q_neg ? -W_MAX : W_MAX;
                    n_state = S_P2_UPD;
                end else begin
                    div_start     = 1'b1;
                    div_req.rem   = {8'b0, am[41:2]};
                    div_req.bits  = {am[1:0], 42'b0};
                    div_req.steps = DIV_STEPS_NORM;
                    div_req.den   = dm;
                    n_state       = S_P2_DWAIT;
                end
            end
            S_P2_DWAIT: begin
                if (div_done) begin
                    n_q     = q_neg ? -t_weight'(q_clip[42:0]) : t_weight'(q_clip[42:0]);
                    n_state = S_P2_UPD;
                end
            end
            S_P2_UPD: begin
                n_diff = r_diff + adq[47:0];
                w_we   = 1'b1;
                w_wa   = r_n;
                w_wd   = r_q;
                if ({1'b0, r_n} + 7'd1 < {1'b0, r_ntop}) begin
                    n_n     = r_n + t_addr'(1);
                    n_state = S_P2_ADDR;
                end else begin
                    n_state = S_I_END;
                end
            end
            // stop test
            S_I_END: begin
                n_iter = iter_nx[15:0];
                n_conv = (r_diff <= {7'b0, r_tol});
                if (r_diff > {7'b0, r_tol} && iter_nx < {1'b0, r_iter_limit}) begin
                    n_state = S_I_INIT;
                end else begin
                    n_oi    = '0;
                    n_state = S_O_ADDR;
                end
            end
            // result delivery
            S_O_ADDR: begin
                n_wa    = r_oi;
                n_state = S_O_WAIT;
            end
            S_O_WAIT: n_state = S_O_HOLD;
            S_O_HOLD: begin
                if (!i_out_stall) begin
                    if (r_oi == r_ntop) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oi    = r_oi + t_addr'(1);
                        n_state = S_O_ADDR;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_cnt   <= '0;
            r_iter_limit <= 16'd10000;
            r_tol        <= 41'd110;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ITER_LIMIT: r_iter_limit <= i_cfg_data[15:0];
                    CFG_TOL:        r_tol        <= i_cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ntop  <= n_ntop;
        r_n     <= n_n;
        r_k     <= n_k;
        r_ua    <= n_ua;
        r_da    <= n_da;
        r_wa    <= n_wa;
        r_upl   <= n_upl;
        r_d1    <= n_d1;
        r_upn   <= n_upn;
        r_den   <= n_den;
        r_cum   <= n_cum;
        r_norm  <= n_norm;
        r_diff  <= n_diff;
        r_qf    <= n_qf;
        r_ql    <= n_ql;
        r_wprev <= n_wprev;
        r_gq    <= n_gq;
        r_t     <= n_t;
        r_q     <= n_q;
        r_iter  <= n_iter;
        r_conv  <= n_conv;
        r_oi    <= n_oi;
    end

    assign o_out_valid           = (r_state == S_O_HOLD);
    assign o_out_state_index     = r_oi;
    assign o_out_weight          = r_wrd;
    assign o_out_converged       = r_conv;
    assign o_out_iterations_used = r_iter;
    assign o_out_is_last_result  = (r_oi == r_ntop);

endmodule

@@ hw/rtl/bdq_checker.sv @@
// Port-level checks for the QSD solver, bound to the top level.
// Depends on birth_death_qsd_recursive_solver_macros.svh and bdq_pkg.
`include "birth_death_qsd_recursive_solver_macros.svh"

module bdq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             i_in_is_last,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [5:0]       o_out_state_index,
    input bdq_pkg::t_weight o_out_weight,
    input logic             o_out_is_last_result
);

    logic        out_held;
    logic [48:0] out_data;
    logic        set_closed;
    logic        last_taken;

    assign out_held   = o_out_valid && i_out_stall;
    assign out_data   = {o_out_state_index, o_out_weight};
    assign set_closed = i_in_valid && !o_in_stall && i_in_is_last;
    assign last_taken = o_out_valid && !i_out_stall && o_out_is_last_result;

    // a stalled result holds
    `BDQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_data))

    // no load request is taken while results are pending
    `BDQ_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // closing the set starts a solve, never an instant result
    `BDQ_ASSERT_NXT(a_solve_start, i_clk, i_rst_n, set_closed, o_in_stall && !o_out_valid)

    // the last result ends the burst
    `BDQ_ASSERT_NXT(a_burst_end, i_clk, i_rst_n, last_taken, !o_out_valid)

endmodule

bind birth_death_qsd_recursive_solver bdq_checker u_bdq_checker (.*);
